[hdl/tlca_pkg.sv]
// Shared types and constants for the binary-lifting common-ancestor block.
// Used by tlca_ctrl, tlca_datapath and tree_lca_binary_lifting.
package tlca_pkg;

	localparam int NODE_W          = 11;
	localparam int DEF_MAX_NODES   = 1024;
	localparam int DEF_LIFT_LEVELS = 11;
	localparam int S_DATA_W        = 24;
	localparam int M_DATA_W        = 16;

	localparam logic [NODE_W-1:0] ROOT_NODE = NODE_W'(1);

	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD,
		OP_QLATCH,
		OP_B0_RD,
		OP_B0_WR,
		OP_BK_RD1,
		OP_BK_RD2,
		OP_BK_WR,
		OP_D_INIT,
		OP_D_RD,
		OP_D_STEP,
		OP_D_WR,
		OP_Q_SHORT,
		OP_Q_DA,
		OP_Q_DB,
		OP_Q_ORDER,
		OP_Q_LRD,
		OP_Q_LSTEP,
		OP_Q_EQ,
		OP_Q_RRD,
		OP_Q_RSTEP,
		OP_Q_FRD,
		OP_Q_FIN,
		OP_Q_OUT
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic idx_last;
		logic lvl_last;
		logic k_zero;
		logic bad;
		logic eq;
	} dp_stat_t;

endpackage

[hdl/tlca_datapath.sv]
// Datapath: parent, jump and depth memories plus the walk registers.
// Executes one command from tlca_ctrl per cycle; depends on tlca_pkg.
module tlca_datapath import tlca_pkg::*; #(
	parameter int MAX_NODES   = DEF_MAX_NODES,
	parameter int LIFT_LEVELS = DEF_LIFT_LEVELS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wen,
	input  logic [NODE_W-1:0] cfg_wdata,
	input  logic [NODE_W-1:0] in_a,
	input  logic [NODE_W-1:0] in_b,
	input  dp_cmd_t           cmd,
	output dp_stat_t          stat,
	output logic [NODE_W-1:0] out_anc,
	output logic              out_bad
);

	localparam int AW   = $clog2(MAX_NODES + 1);
	localparam int LW   = $clog2(LIFT_LEVELS);
	localparam int DW   = $clog2(MAX_NODES);
	localparam int SUMW = (LIFT_LEVELS + 1 > DW) ? LIFT_LEVELS + 1 : DW;
	localparam int CW   = (AW > NODE_W) ? AW : NODE_W;
	localparam int JD   = LIFT_LEVELS * (2 ** AW);

	logic [NODE_W-1:0] par_mem [0:MAX_NODES];
	logic [NODE_W-1:0] jmp_mem [0:JD-1];
	logic [DW-1:0]     dep_mem [0:MAX_NODES];

	logic [NODE_W-1:0] ncfg_q;
	logic [NODE_W-1:0] qa_q, qb_q, v_q, w_q, ans_q, rd0_q, rd1_q, pd_q;
	logic              bad_q;
	logic [AW-1:0]     idx_q;
	logic [LW-1:0]     lvl_q, k_q;
	logic [SUMW-1:0]   d_q;
	logic [DW-1:0]     diff_q, da_q, depr_q;
	logic [NODE_W-1:0] out_anc_q;
	logic              out_bad_q;

	logic [CW-1:0]     n_act;
	logic              idx_last;
	logic [AW-1:0]     idx_next;
	logic [SUMW-1:0]   pw, d_fin;
	logic [NODE_W-1:0] fixp;
	logic              ren0, ren1, jwen;
	logic [LW-1:0]     rl0, wl;
	logic [AW-1:0]     ri0, ri1;
	logic [NODE_W-1:0] jwd;
	logic              a_ok, b_ok, p_ok;

	always_comb begin
		if (ncfg_q == '0) begin
			n_act = CW'(1);
		end else if (CW'(ncfg_q) > CW'(MAX_NODES)) begin
			n_act = CW'(MAX_NODES);
		end else begin
			n_act = CW'(ncfg_q);
		end
	end

	assign a_ok     = (CW'(in_a) >= CW'(1)) && (CW'(in_a) <= n_act);
	assign b_ok     = (CW'(in_b) >= CW'(1)) && (CW'(in_b) <= n_act);
	assign p_ok     = (CW'(pd_q) >= CW'(1)) && (CW'(pd_q) <= n_act);
	assign idx_last = (idx_q == AW'(MAX_NODES));
	assign idx_next = idx_last ? AW'(1) : idx_q + AW'(1);
	assign pw       = SUMW'(1) << k_q;
	assign d_fin    = d_q + SUMW'(v_q != ROOT_NODE);

	// Out-of-range or root entries point at the root.
	assign fixp = ((idx_q == AW'(1)) || (CW'(idx_q) > n_act) || !p_ok) ? ROOT_NODE : pd_q;

	always_comb begin
		ren0 = 1'b0;
		ren1 = 1'b0;
		jwen = 1'b0;
		rl0  = k_q;
		ri0  = AW'(v_q);
		ri1  = AW'(v_q);
		wl   = lvl_q;
		jwd  = rd0_q;
		case (cmd.op)
			OP_B0_WR: begin
				jwen = 1'b1;
				wl   = '0;
				jwd  = fixp;
			end
			OP_BK_RD1: begin
				ren0 = 1'b1;
				rl0  = lvl_q - LW'(1);
				ri0  = idx_q;
			end
			OP_BK_RD2: begin
				ren0 = 1'b1;
				rl0  = lvl_q - LW'(1);
				ri0  = AW'(rd0_q);
			end
			OP_BK_WR: begin
				jwen = 1'b1;
			end
			OP_D_RD, OP_Q_LRD: begin
				ren0 = 1'b1;
			end
			OP_Q_RRD: begin
				ren0 = 1'b1;
				ren1 = 1'b1;
				ri0  = AW'(w_q);
			end
			OP_Q_FRD: begin
				ren0 = 1'b1;
				rl0  = '0;
				ri0  = AW'(w_q);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (ren0) begin
			rd0_q <= jmp_mem[{rl0, ri0}];
		end
		if (ren1) begin
			rd1_q <= jmp_mem[{k_q, ri1}];
		end
		if (jwen) begin
			jmp_mem[{wl, idx_q}] <= jwd;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_LOAD && a_ok && CW'(in_a) >= CW'(2)) begin
			par_mem[AW'(in_a)] <= in_b;
		end
		if (cmd.op == OP_B0_RD) begin
			pd_q <= par_mem[idx_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_D_WR) begin
			dep_mem[idx_q] <= (d_fin > SUMW'(MAX_NODES - 1)) ? DW'(MAX_NODES - 1) : DW'(d_fin);
		end
		if (cmd.op == OP_Q_DA) begin
			depr_q <= dep_mem[AW'(qa_q)];
		end
		if (cmd.op == OP_Q_DB) begin
			depr_q <= dep_mem[AW'(qb_q)];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ncfg_q <= NODE_W'(1);
		end else if (cfg_wen) begin
			ncfg_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				idx_q <= AW'(1);
			end
			OP_QLATCH: begin
				qa_q  <= in_a;
				qb_q  <= in_b;
				bad_q <= !(a_ok && b_ok);
			end
			OP_B0_WR: begin
				idx_q <= idx_next;
				if (idx_last) begin
					lvl_q <= LW'(1);
				end
			end
			OP_BK_WR: begin
				idx_q <= idx_next;
				if (idx_last) begin
					lvl_q <= lvl_q + LW'(1);
				end
			end
			OP_D_INIT: begin
				v_q <= NODE_W'(idx_q);
				d_q <= '0;
				k_q <= LW'(LIFT_LEVELS - 1);
			end
			OP_D_STEP: begin
				if (rd0_q != ROOT_NODE) begin
					d_q <= d_q + pw;
					v_q <= rd0_q;
				end
				if (k_q != '0) begin
					k_q <= k_q - LW'(1);
				end
			end
			OP_D_WR: begin
				idx_q <= idx_next;
			end
			OP_Q_SHORT: begin
				ans_q <= bad_q ? '0 : ROOT_NODE;
			end
			OP_Q_DB: begin
				da_q <= depr_q;
			end
			OP_Q_ORDER: begin
				k_q <= LW'(LIFT_LEVELS - 1);
				if (da_q > depr_q) begin
					w_q    <= qb_q;
					v_q    <= qa_q;
					diff_q <= da_q - depr_q;
				end else begin
					w_q    <= qa_q;
					v_q    <= qb_q;
					diff_q <= depr_q - da_q;
				end
			end
			OP_Q_LSTEP: begin
				if (SUMW'(diff_q) >= pw) begin
					v_q    <= rd0_q;
					diff_q <= DW'(SUMW'(diff_q) - pw);
				end
				if (k_q != '0) begin
					k_q <= k_q - LW'(1);
				end
			end
			OP_Q_EQ: begin
				ans_q <= w_q;
				k_q   <= LW'(LIFT_LEVELS - 1);
			end
			OP_Q_RSTEP: begin
				if (rd0_q != rd1_q) begin
					w_q <= rd0_q;
					v_q <= rd1_q;
				end
				if (k_q != '0) begin
					k_q <= k_q - LW'(1);
				end
			end
			OP_Q_FIN: begin
				ans_q <= rd0_q;
			end
			OP_Q_OUT: begin
				out_anc_q <= ans_q;
				out_bad_q <= bad_q;
			end
			default: begin
			end
		endcase
	end

	assign stat.idx_last = idx_last;
	assign stat.lvl_last = (lvl_q == LW'(LIFT_LEVELS - 1));
	assign stat.k_zero   = (k_q == '0);
	assign stat.bad      = bad_q;
	assign stat.eq       = (v_q == w_q);
	assign out_anc       = out_anc_q;
	assign out_bad       = out_bad_q;

endmodule

[hdl/tlca_ctrl.sv]
// Controller state machine: sequences table build and queries.
// Drives tlca_datapath through dp_cmd_t; depends on tlca_pkg.
module tlca_ctrl import tlca_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  logic     in_mode,
	input  logic     in_last,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	typedef enum logic [4:0] {
		S_IDLE, S_B0_RD, S_B0_WR, S_BK_RD1, S_BK_RD2, S_BK_WR,
		S_D_INIT, S_D_RD, S_D_STEP, S_D_WR,
		S_Q_CHK, S_Q_DB, S_Q_ORDER, S_Q_LRD, S_Q_LSTEP, S_Q_EQ,
		S_Q_RRD, S_Q_RSTEP, S_Q_FRD, S_Q_FIN, S_Q_OUT
	} state_t;

	state_t state_q;
	logic   built_q;
	logic   out_valid_q;
	logic   can_out;
	logic   accept;

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign can_out   = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd.op = OP_NONE;
		unique case (state_q)
			S_IDLE:    if (in_valid) cmd.op = in_mode ? OP_QLATCH : OP_LOAD;
			S_B0_RD:   cmd.op = OP_B0_RD;
			S_B0_WR:   cmd.op = OP_B0_WR;
			S_BK_RD1:  cmd.op = OP_BK_RD1;
			S_BK_RD2:  cmd.op = OP_BK_RD2;
			S_BK_WR:   cmd.op = OP_BK_WR;
			S_D_INIT:  cmd.op = OP_D_INIT;
			S_D_RD:    cmd.op = OP_D_RD;
			S_D_STEP:  cmd.op = OP_D_STEP;
			S_D_WR:    cmd.op = OP_D_WR;
			S_Q_CHK:   cmd.op = (stat.bad || !built_q) ? OP_Q_SHORT : OP_Q_DA;
			S_Q_DB:    cmd.op = OP_Q_DB;
			S_Q_ORDER: cmd.op = OP_Q_ORDER;
			S_Q_LRD:   cmd.op = OP_Q_LRD;
			S_Q_LSTEP: cmd.op = OP_Q_LSTEP;
			S_Q_EQ:    cmd.op = OP_Q_EQ;
			S_Q_RRD:   cmd.op = OP_Q_RRD;
			S_Q_RSTEP: cmd.op = OP_Q_RSTEP;
			S_Q_FRD:   cmd.op = OP_Q_FRD;
			S_Q_FIN:   cmd.op = OP_Q_FIN;
			S_Q_OUT:   if (can_out) cmd.op = OP_Q_OUT;
			default:   cmd.op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			built_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// Raise valid on a new result, drop it once the old one transfers.
			if (state_q == S_Q_OUT && can_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (in_mode) begin
							state_q <= S_Q_CHK;
						end else if (in_last) begin
							state_q <= S_B0_RD;
						end else begin
							built_q <= 1'b0;
						end
					end
				end
				S_B0_RD:  state_q <= S_B0_WR;
				S_B0_WR:  state_q <= stat.idx_last ? S_BK_RD1 : S_B0_RD;
				S_BK_RD1: state_q <= S_BK_RD2;
				S_BK_RD2: state_q <= S_BK_WR;
				S_BK_WR: begin
					if (!stat.idx_last) begin
						state_q <= S_BK_RD1;
					end else begin
						state_q <= stat.lvl_last ? S_D_INIT : S_BK_RD1;
					end
				end
				S_D_INIT: state_q <= S_D_RD;
				S_D_RD:   state_q <= S_D_STEP;
				S_D_STEP: state_q <= stat.k_zero ? S_D_WR : S_D_RD;
				S_D_WR: begin
					if (stat.idx_last) begin
						built_q <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_D_INIT;
					end
				end
				S_Q_CHK:   state_q <= (stat.bad || !built_q) ? S_Q_OUT : S_Q_DB;
				S_Q_DB:    state_q <= S_Q_ORDER;
				S_Q_ORDER: state_q <= S_Q_LRD;
				S_Q_LRD:   state_q <= S_Q_LSTEP;
				S_Q_LSTEP: state_q <= stat.k_zero ? S_Q_EQ : S_Q_LRD;
				S_Q_EQ:    state_q <= stat.eq ? S_Q_OUT : S_Q_RRD;
				S_Q_RRD:   state_q <= S_Q_RSTEP;
				S_Q_RSTEP: state_q <= stat.k_zero ? S_Q_FRD : S_Q_RRD;
				S_Q_FRD:   state_q <= S_Q_FIN;
				S_Q_FIN:   state_q <= S_Q_OUT;
				S_Q_OUT: begin
					if (can_out) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_query_enters_check: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && in_mode) |=> (state_q == S_Q_CHK))
		else $error("query transfer did not start the range check");

	a_built_from_depth: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(built_q) |-> ($past(state_q) == S_D_WR))
		else $error("table marked built outside the depth pass");

	a_result_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == S_Q_OUT))
		else $error("result raised outside the output state");

	a_load_clears_built: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !in_mode && !in_last) |=> !built_q)
		else $error("load without last entry left table marked built");

endmodule

[hdl/tree_lca_binary_lifting.sv]
// Lowest common ancestor by binary lifting: loads, table build and queries.
// Entries are taken only while idle; the last load entry starts a build of the
// level-0 jump table, then the higher lifting levels, then the node depths.
// Query: on a bad node or unbuilt table the result skips the walk; else the deeper
// node lifts with one jump-table read per level, then both rise with two per level.
// Reset (arst_n low) clears state machine, built flag, result valid; node_count = 1.
module tree_lca_binary_lifting import tlca_pkg::*; #(
	parameter int MAX_NODES   = DEF_MAX_NODES,
	parameter int LIFT_LEVELS = DEF_LIFT_LEVELS
) (
	input  logic                clk,
	input  logic                arst_n,
	// configuration: node_count
	input  logic                cfg_wen,
	input  logic [NODE_W-1:0]   cfg_wdata,
	// input stream
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [S_DATA_W-1:0] s_tdata,   // node_a [10:0], node_b [21:11], zero pad
	input  logic                s_tuser,   // mode: 0 load parent, 1 query
	input  logic                s_tlast,   // last_entry
	// result stream
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [M_DATA_W-1:0] m_tdata,   // ancestor [10:0], zero pad
	output logic                m_tuser    // bad_node
);

	dp_cmd_t           cmd;
	dp_stat_t          stat;
	logic [NODE_W-1:0] anc;

	// Controller owns sequencing, the built flag and the result valid bit.
	tlca_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_mode   (s_tuser),
		.in_last   (s_tlast),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Datapath holds the memories, walk registers and the result register.
	tlca_datapath #(
		.MAX_NODES   (MAX_NODES),
		.LIFT_LEVELS (LIFT_LEVELS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.in_a      (s_tdata[NODE_W-1:0]),
		.in_b      (s_tdata[2*NODE_W-1:NODE_W]),
		.cmd       (cmd),
		.stat      (stat),
		.out_anc   (anc),
		.out_bad   (m_tuser)
	);

	// Pad the result word to whole bytes.
	assign m_tdata = M_DATA_W'(anc);

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for tree_lca_binary_lifting: tree loads, table builds and
// common-ancestor queries, with a class-based predictor. Depends on tlca_pkg and tree_lca_binary_lifting.
module tb_top;
	import tlca_pkg::*;

	localparam int NODES      = DEF_MAX_NODES;
	localparam int LEVELS     = DEF_LIFT_LEVELS;
	localparam int BUILD_CYC  = 2*NODES + 3*NODES*(LEVELS-1) + NODES*(2*LEVELS+2);
	localparam int TREE_N     = 128;
	localparam int CHAIN_N    = 100;
	localparam bit MODE_LOAD  = 1'b0;
	localparam bit MODE_QUERY = 1'b1;

	typedef struct {
		logic [NODE_W-1:0] ancestor;
		logic              bad_node;
	} answer_t;

	// Tree model: parent entries, lifting table and depths for nodes 1..NODES.
	class lca_scoreboard;
		logic [NODE_W-1:0] count_reg;
		int                parent[NODES+1];
		int                jump[NODES+1][LEVELS];
		int                dep[NODES+1];
		bit                built;
		answer_t           pending_answers[$];
		int                errors;

		function new();
			count_reg = 1;
			built     = 0;
			errors    = 0;
			for (int i = 0; i <= NODES; i++) begin
				parent[i] = 0;
				dep[i]    = 0;
				for (int k = 0; k < LEVELS; k++) jump[i][k] = 0;
			end
		endfunction

		// Zero acts as one node, anything above the table size saturates.
		function int active_nodes();
			if (count_reg == 0) return 1;
			if (count_reg > NODES) return NODES;
			return count_reg;
		endfunction

		function void rebuild();
			int n, v, d, p;
			n = active_nodes();
			for (int i = 1; i <= NODES; i++) begin
				p = parent[i];
				if (i == ROOT_NODE || i > n || p < 1 || p > n) p = ROOT_NODE;
				jump[i][0] = p;
			end
			for (int k = 1; k < LEVELS; k++)
				for (int i = 1; i <= NODES; i++)
					jump[i][k] = jump[jump[i][k-1]][k-1];
			for (int i = 1; i <= NODES; i++) begin
				v = i;
				d = 0;
				for (int k = LEVELS-1; k >= 0; k--) begin
					if (jump[v][k] != ROOT_NODE) begin
						d += 1 << k;
						v = jump[v][k];
					end
				end
				if (v != ROOT_NODE) d += 1;
				if (d > NODES-1) d = NODES-1;
				dep[i] = d;
			end
			built = 1;
		endfunction

		function int common_ancestor(int a, int b);
			int sh, dp, diff;
			sh = a;
			dp = b;
			if (dep[a] > dep[b]) begin
				sh = b;
				dp = a;
			end
			diff = dep[dp] - dep[sh];
			for (int k = LEVELS-1; k >= 0; k--) begin
				if (diff >= (1 << k)) begin
					dp = jump[dp][k];
					diff -= 1 << k;
				end
			end
			if (dp == sh) return sh;
			for (int k = LEVELS-1; k >= 0; k--) begin
				if (jump[sh][k] != jump[dp][k]) begin
					sh = jump[sh][k];
					dp = jump[dp][k];
				end
			end
			return jump[sh][0];
		endfunction

		function void note_input(bit mode, logic [NODE_W-1:0] a, logic [NODE_W-1:0] b,
				bit last);
			answer_t r;
			int n;
			n = active_nodes();
			if (mode == MODE_LOAD) begin
				if (a >= 2 && a <= n) parent[a] = b;
				if (last) rebuild();
				else built = 0;
				return;
			end
			if (a < 1 || a > n || b < 1 || b > n) begin
				r.ancestor = '0;
				r.bad_node = 1'b1;
			end else begin
				r.ancestor = built ? NODE_W'(common_ancestor(a, b)) : ROOT_NODE;
				r.bad_node = 1'b0;
			end
			pending_answers.push_back(r);
		endfunction

		function void check_result(logic [NODE_W-1:0] ancestor, logic bad_node);
			answer_t r;
			if (pending_answers.size() == 0) begin
				$error("result with nothing expected: ancestor %0d bad_node %0d",
					ancestor, bad_node);
				errors++;
				return;
			end
			r = pending_answers.pop_front();
			if (ancestor !== r.ancestor) begin
				$error("ancestor: expected %0d, got %0d", r.ancestor, ancestor);
				errors++;
			end
			if (bad_node !== r.bad_node) begin
				$error("bad_node: expected %0d, got %0d", r.bad_node, bad_node);
				errors++;
			end
		endfunction
	endclass

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                cfg_wen   = 1'b0;
	logic [NODE_W-1:0]   cfg_wdata = '0;
	logic                s_tvalid  = 1'b0;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata   = '0;
	logic                s_tuser   = 1'b0;
	logic                s_tlast   = 1'b0;
	logic                m_tvalid;
	logic                m_tready  = 1'b0;
	logic [M_DATA_W-1:0] m_tdata;
	logic                m_tuser;

	lca_scoreboard tree_sb = new();
	int            src_gap_pct   = 0;
	int            snk_stall_pct = 0;
	bit            last_was_load = 0;

	tree_lca_binary_lifting dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wen  (cfg_wen),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #5 clk = ~clk;

	// Result side: check every transfer, stall at random per the current idle mix.
	always @(posedge clk) begin
		if (m_tvalid && m_tready) tree_sb.check_result(m_tdata[NODE_W-1:0], m_tuser);
		m_tready <= ($urandom_range(0, 99) >= snk_stall_pct);
	end

	// Drop valid and let cycles pass; drain also quiets the sender.
	task automatic hold_off(int cycles);
		s_tvalid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// Present one item and hold it until the transfer; valid stays high on return
	// so back-to-back items need no gap.
	task automatic send_item(bit mode, logic [NODE_W-1:0] a, logic [NODE_W-1:0] b, bit last);
		while ($urandom_range(0, 99) < src_gap_pct) hold_off(1);
		s_tvalid <= 1'b1;
		s_tuser  <= mode;
		s_tlast  <= last;
		s_tdata  <= {{(S_DATA_W-2*NODE_W){1'b0}}, b, a};
		do @(posedge clk); while (!s_tready);
		tree_sb.note_input(mode, a, b, last);
		last_was_load = (mode == MODE_LOAD);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (tree_sb.pending_answers.size() != 0) @(posedge clk);
	endtask

	// Write node_count only when idle; a trailing load may still be building.
	task automatic set_node_count(logic [NODE_W-1:0] value);
		drain();
		repeat (last_was_load ? BUILD_CYC + 100 : 20) @(posedge clk);
		cfg_wen   <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_wen <= 1'b0;
		tree_sb.count_reg = value;
	endtask

	function automatic logic [NODE_W-1:0] pick_node(int n);
		case ($urandom_range(0, 19))
			0:       return '0;
			1:       return (n + 1 > 2047) ? NODE_W'(2047) : NODE_W'(n + 1);
			2:       return NODE_W'(2047);
			3:       return NODE_W'($urandom_range(0, 2047));
			default: return NODE_W'($urandom_range(1, n));
		endcase
	endfunction

	task automatic random_queries(int count, int n);
		for (int q = 0; q < count; q++)
			send_item(MODE_QUERY, pick_node(n), pick_node(n), 1'($urandom_range(0, 1)));
	endtask

	// Random parent for node i: mostly a lower node (a proper tree), some junk.
	function automatic logic [NODE_W-1:0] pick_parent(int i);
		case ($urandom_range(0, 39))
			0:       return '0;
			1:       return NODE_W'($urandom_range(1025, 2047));
			2:       return NODE_W'($urandom_range(1, NODES));
			default: return NODE_W'($urandom_range(1, i - 1));
		endcase
	endfunction

	initial begin
		int n;
		src_gap_pct   = 9;
		snk_stall_pct = 81;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Before any build: root answer, range check on both nodes.
		send_item(MODE_QUERY, 1, 1, 0);
		send_item(MODE_QUERY, 0, 1, 1);
		send_item(MODE_QUERY, 1, 2047, 0);
		send_item(MODE_QUERY, 2, 1, 0);

		// Random tree; every entry up to the node count is loaded before the build.
		set_node_count(NODE_W'(TREE_N));
		send_item(MODE_LOAD, 0, 5, 0);
		send_item(MODE_LOAD, 1, 7, 0);
		send_item(MODE_LOAD, 2047, 2047, 0);
		send_item(MODE_QUERY, 3, 2, 0);
		for (int i = 2; i <= TREE_N; i++)
			send_item(MODE_LOAD, NODE_W'(i), pick_parent(i), i == TREE_N);
		send_item(MODE_QUERY, 1, 1, 0);
		send_item(MODE_QUERY, NODE_W'(TREE_N), NODE_W'(TREE_N), 0);
		send_item(MODE_QUERY, NODE_W'(TREE_N), 1, 0);
		send_item(MODE_QUERY, NODE_W'(TREE_N + 1), 3, 0);
		random_queries(40, TREE_N);
		// Let the pipe run dry once before resuming.
		drain();
		random_queries(40, TREE_N);

		// Swap the idle mix: sender mostly quiet, receiver mostly ready.
		src_gap_pct   = 81;
		snk_stall_pct = 9;

		// Zero node count acts as one: only the root is legal.
		set_node_count(0);
		send_item(MODE_QUERY, 1, 1, 0);
		send_item(MODE_QUERY, 2, 1, 0);

		// A single chain spreads depths over several lifting levels.
		set_node_count(NODE_W'(CHAIN_N));
		for (int i = 2; i <= CHAIN_N; i++)
			send_item(MODE_LOAD, NODE_W'(i), NODE_W'(i - 1), i == CHAIN_N);
		send_item(MODE_QUERY, NODE_W'(CHAIN_N), NODE_W'(CHAIN_N - 1), 0);
		send_item(MODE_QUERY, NODE_W'(CHAIN_N), 1, 0);
		send_item(MODE_QUERY, 37, 90, 0);
		random_queries(30, CHAIN_N);

		// Oversized count saturates at the table size; the last build stays in use.
		set_node_count(2047);
		send_item(MODE_QUERY, NODE_W'(NODES), NODE_W'(CHAIN_N), 0);
		send_item(MODE_QUERY, NODE_W'(NODES + 1), 1, 0);
		send_item(MODE_QUERY, NODE_W'(NODES), NODE_W'(NODES), 0);

		// Small trees; the last three rounds run with no idling, one loads a two-node cycle.
		for (int r = 0; r < 6; r++) begin
			if (r == 3) begin
				src_gap_pct   = 0;
				snk_stall_pct = 0;
			end
			n = (r == 0) ? 2 : $urandom_range(3, 48);
			set_node_count(NODE_W'(n));
			for (int i = 2; i <= n; i++) begin
				if ($urandom_range(0, 15) == 0)
					send_item(MODE_LOAD, NODE_W'($urandom_range(n + 1, 2047)), 1, 0);
				if ($urandom_range(0, 15) == 0)
					send_item(MODE_QUERY, pick_node(n), pick_node(n), 0);
				send_item(MODE_LOAD, NODE_W'(i), (i > 2) ? pick_parent(i) : NODE_W'(1), 0);
			end
			if (r == 4 && n >= 3) begin
				send_item(MODE_LOAD, 2, 3, 0);
				send_item(MODE_LOAD, 3, 2, 0);
			end
			send_item(MODE_LOAD, NODE_W'($urandom_range(1, n)), pick_parent(n + 1), 1);
			random_queries(40, n);
		end

		drain();
		repeat (200) @(posedge clk);
		if (tree_sb.errors == 0 && tree_sb.pending_answers.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	// Watchdog: far above the slowest legal run (eight full builds plus stalls).
	initial begin
		#40ms;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
